// ===== rtl/apd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// apd_pkg
// Shared types and constants for the attitude PD and rigid-body rate pipeline.
// ----------------------------------------------------------------------------
package apd_pkg;

    localparam int FIELD_W   = 32;
    localparam int WIDE_W    = 48;
    localparam int CFG_IDX_W = 3;

    // Largest magnitude of an intermediate term, 2^47 - 1.
    localparam logic [WIDE_W-1:0] WIDE_MAX = 48'h7FFF_FFFF_FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INERTIA_X = 3'd0,
        REG_INERTIA_Y = 3'd1,
        REG_INERTIA_Z = 3'd2,
        REG_GAIN_PROP = 3'd3,
        REG_GAIN_DERIV = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] quat_a;
        logic signed [FIELD_W-1:0] quat_b;
        logic signed [FIELD_W-1:0] quat_c;
        logic signed [FIELD_W-1:0] quat_d;
        logic signed [FIELD_W-1:0] omega_x;
        logic signed [FIELD_W-1:0] omega_y;
        logic signed [FIELD_W-1:0] omega_z;
        logic signed [FIELD_W-1:0] target_a;
        logic signed [FIELD_W-1:0] target_b;
        logic signed [FIELD_W-1:0] target_c;
        logic signed [FIELD_W-1:0] target_d;
    } sample_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] rate_quat_a;
        logic signed [FIELD_W-1:0] rate_quat_b;
        logic signed [FIELD_W-1:0] rate_quat_c;
        logic signed [FIELD_W-1:0] rate_quat_d;
        logic signed [FIELD_W-1:0] accel_x;
        logic signed [FIELD_W-1:0] accel_y;
        logic signed [FIELD_W-1:0] accel_z;
        logic                      zero_norm;
    } result_t;

endpackage
`default_nettype wire

// ===== rtl/attitude_pd_dynamics_rates.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// attitude_pd_dynamics_rates
// Quaternion kinematic rates, PD attitude torque and Euler rigid-body
// accelerations in Q8.24 fixed point.
// ----------------------------------------------------------------------------
// The block takes one item in every cycle and busy never rises. Each result
// appears on result with done high, in the order taken, and must be captured
// then. Each item passes through the 32-stage square root of the norm, the
// 25-stage normalising dividers, the 32-stage dividers by the inertias and
// eleven stages of squaring, multiplying, summing and output registers.
// Configuration writes are always taken and should only be made while no
// item is in flight.
module attitude_pd_dynamics_rates
    import apd_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  sample_t              sample,
    output logic                 done,
    output result_t              result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FIELD_W-1:0]   cfg_data
);

    localparam int OUT_BITS = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
    localparam logic signed [35:0] LIM = 36'((64'sd1 <<< (OUT_BITS - 1)) - 64'sd1);
    localparam logic signed [35:0] LIM_NEG = -LIM - 36'sd1;
    localparam logic signed [48:0] WIDE_POS = 49'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [48:0] WIDE_NEG = -WIDE_POS;
    localparam int LATENCY = 100;

    typedef struct packed {
        logic [3:0]                q_neg;
        logic signed [FIELD_W-1:0] omega_x;
        logic signed [FIELD_W-1:0] omega_y;
        logic signed [FIELD_W-1:0] omega_z;
        logic signed [FIELD_W-1:0] target_a;
        logic signed [FIELD_W-1:0] target_b;
        logic signed [FIELD_W-1:0] target_c;
        logic signed [FIELD_W-1:0] target_d;
    } late_t;

    typedef struct packed {
        logic ovf;
        logic neg;
        logic nil;
    } acc_side_t;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? $unsigned(-v) : $unsigned(v);
    endfunction

    function automatic logic signed [47:0] clamp_wide(input logic signed [48:0] v);
        logic signed [48:0] c;
        c = v;
        if (v > WIDE_POS)
        begin
            c = WIDE_POS;
        end
        else if (v < WIDE_NEG)
        begin
            c = WIDE_NEG;
        end
        return c[47:0];
    endfunction

    function automatic logic [31:0] sat_out(input logic signed [35:0] v);
        logic signed [35:0] c;
        c = v;
        if (v > LIM)
        begin
            c = LIM;
        end
        else if (v < LIM_NEG)
        begin
            c = LIM_NEG;
        end
        return c[31:0];
    endfunction

    // Configuration registers.
    logic [31:0] inertia_x_reg;
    logic [31:0] inertia_y_reg;
    logic [31:0] inertia_z_reg;
    logic [31:0] gain_prop_reg;
    logic [31:0] gain_deriv_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inertia_x_reg  <= 32'd65536;
            inertia_y_reg  <= 32'd65536;
            inertia_z_reg  <= 32'd65536;
            gain_prop_reg  <= 32'd0;
            gain_deriv_reg <= 32'd65536;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_INERTIA_X:  inertia_x_reg  <= cfg_data;
                REG_INERTIA_Y:  inertia_y_reg  <= cfg_data;
                REG_INERTIA_Z:  inertia_z_reg  <= cfg_data;
                REG_GAIN_PROP:  gain_prop_reg  <= cfg_data;
                REG_GAIN_DERIV: gain_deriv_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Valid bits travel alongside the datapath.
    logic                accept;
    logic [LATENCY-1:0]  valid_reg;

    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[LATENCY-2:0], accept};
        end
    end

    assign done = valid_reg[LATENCY-1];

    // Squares and their saturating sum.
    logic [31:0] q_mag_in [4];
    logic [62:0] sq_reg [4];
    logic [64:0] sum_full;
    logic [63:0] sum_reg;
    logic        zero_reg;

    assign q_mag_in[0] = mag32(sample.quat_a);
    assign q_mag_in[1] = mag32(sample.quat_b);
    assign q_mag_in[2] = mag32(sample.quat_c);
    assign q_mag_in[3] = mag32(sample.quat_d);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            sq_reg[i] <= 63'(q_mag_in[i]) * 63'(q_mag_in[i]);
        end
    end

    assign sum_full = 65'(sq_reg[0]) + 65'(sq_reg[1]) + 65'(sq_reg[2]) + 65'(sq_reg[3]);

    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_full[64] ? {64{1'b1}} : sum_full[63:0];
        zero_reg <= (sum_full == '0);
    end

    // Norm.
    logic [31:0] norm;

    apd_sqrt u_sqrt (
        .clk      (clk),
        .radicand (sum_reg),
        .root     (norm)
    );

    logic [$bits(sample_t)-1:0] sample33_bits;
    sample_t                    sample33;

    apd_delay #(.WIDTH($bits(sample_t)), .DEPTH(34)) u_dly_sample (
        .clk  (clk),
        .din  (sample),
        .dout (sample33_bits)
    );

    assign sample33 = sample_t'(sample33_bits);

    // Normalised components: each magnitude is at most the norm, so the
    // quotient needs only 25 bits.
    logic [31:0] q_mag33 [4];
    logic [24:0] n_mag [4];
    late_t       late33;
    logic [$bits(late_t)-1:0] late58_bits;
    late_t       late58;

    assign q_mag33[0] = mag32(sample33.quat_a);
    assign q_mag33[1] = mag32(sample33.quat_b);
    assign q_mag33[2] = mag32(sample33.quat_c);
    assign q_mag33[3] = mag32(sample33.quat_d);

    for (genvar i = 0; i < 4; i++)
    begin : g_norm
        apd_div #(.Q_W(25), .D_W(32)) u_div (
            .clk      (clk),
            .rem_init ({1'b0, q_mag33[i][31:1]}),
            .low_bits ({q_mag33[i][0], 24'd0}),
            .divisor  (norm),
            .quotient (n_mag[i])
        );
    end

    assign late33.q_neg    = {sample33.quat_d[31], sample33.quat_c[31],
                              sample33.quat_b[31], sample33.quat_a[31]};
    assign late33.omega_x  = sample33.omega_x;
    assign late33.omega_y  = sample33.omega_y;
    assign late33.omega_z  = sample33.omega_z;
    assign late33.target_a = sample33.target_a;
    assign late33.target_b = sample33.target_b;
    assign late33.target_c = sample33.target_c;
    assign late33.target_d = sample33.target_d;

    apd_delay #(.WIDTH($bits(late_t)), .DEPTH(25)) u_dly_late (
        .clk  (clk),
        .din  (late33),
        .dout (late58_bits)
    );

    assign late58 = late_t'(late58_bits);

    // First products.
    logic signed [25:0]  n [4];
    logic signed [31:0]  w58 [3];
    logic signed [31:0]  t58 [4];
    logic signed [32:0]  dif [3];
    logic signed [47:0]  nw [4][3];
    logic signed [47:0]  nt [4][4];
    logic signed [47:0]  g1 [3];
    logic signed [47:0]  kdw [3];

    for (genvar i = 0; i < 4; i++)
    begin : g_n
        assign n[i] = late58.q_neg[i] ? -$signed({1'b0, n_mag[i]}) : $signed({1'b0, n_mag[i]});
    end

    assign w58[0] = late58.omega_x;
    assign w58[1] = late58.omega_y;
    assign w58[2] = late58.omega_z;
    assign t58[0] = late58.target_a;
    assign t58[1] = late58.target_b;
    assign t58[2] = late58.target_c;
    assign t58[3] = late58.target_d;

    assign dif[0] = $signed({1'b0, inertia_y_reg}) - $signed({1'b0, inertia_z_reg});
    assign dif[1] = $signed({1'b0, inertia_z_reg}) - $signed({1'b0, inertia_x_reg});
    assign dif[2] = $signed({1'b0, inertia_x_reg}) - $signed({1'b0, inertia_y_reg});

    for (genvar i = 0; i < 4; i++)
    begin : g_nrow
        for (genvar j = 0; j < 3; j++)
        begin : g_nw
            apd_mul #(.A_W(26), .B_W(32), .SHIFT(24)) u_mul (
                .clk (clk),
                .a   (n[i]),
                .b   (w58[j]),
                .p   (nw[i][j])
            );
        end
        for (genvar j = 0; j < 4; j++)
        begin : g_nt
            apd_mul #(.A_W(26), .B_W(32), .SHIFT(24)) u_mul (
                .clk (clk),
                .a   (n[i]),
                .b   (t58[j]),
                .p   (nt[i][j])
            );
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_first_axis
        apd_mul #(.A_W(33), .B_W(32), .SHIFT(16)) u_gyro (
            .clk (clk),
            .a   (dif[i]),
            .b   (w58[(i + 1) % 3]),
            .p   (g1[i])
        );
        apd_mul #(.A_W(33), .B_W(32), .SHIFT(16)) u_kd (
            .clk (clk),
            .a   ($signed({1'b0, gain_deriv_reg})),
            .b   (w58[i]),
            .p   (kdw[i])
        );
    end

    // Sums of the kinematic rates and of the error quaternion.
    logic signed [47:0] r_sum [4];
    logic signed [47:0] qe_sum [4];
    logic signed [34:0] r_reg [4];
    logic signed [34:0] qe_reg [4];
    logic signed [47:0] g1_reg [3];

    assign r_sum[0]  = nw[1][2] - nw[2][1] + nw[3][0];
    assign r_sum[1]  = nw[2][0] - nw[0][2] + nw[3][1];
    assign r_sum[2]  = nw[0][1] - nw[1][0] + nw[3][2];
    assign r_sum[3]  = -nw[0][0] - nw[1][1] - nw[2][2];
    assign qe_sum[0] = nt[0][3] + nt[1][2] - nt[2][1] - nt[3][0];
    assign qe_sum[1] = nt[2][0] - nt[0][2] + nt[1][3] - nt[3][1];
    assign qe_sum[2] = nt[0][1] - nt[1][0] + nt[2][3] - nt[3][2];
    assign qe_sum[3] = nt[0][0] + nt[1][1] + nt[2][2] + nt[3][3];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            r_reg[i]  <= 35'(r_sum[i]);
            qe_reg[i] <= 35'(qe_sum[i]);
        end
        for (int i = 0; i < 3; i++)
        begin
            g1_reg[i] <= g1[i];
        end
    end

    logic [95:0]         w61_bits;
    logic signed [31:0]  w61 [3];

    apd_delay #(.WIDTH(96), .DEPTH(3)) u_dly_omega (
        .clk  (clk),
        .din  ({late58.omega_z, late58.omega_y, late58.omega_x}),
        .dout (w61_bits)
    );

    assign w61[0] = w61_bits[31:0];
    assign w61[1] = w61_bits[63:32];
    assign w61[2] = w61_bits[95:64];

    // Second and third products.
    logic signed [47:0] qq [3];
    logic signed [47:0] gyro [3];
    logic signed [47:0] kpm [3];

    for (genvar i = 0; i < 3; i++)
    begin : g_second
        apd_mul #(.A_W(35), .B_W(35), .SHIFT(24)) u_qq (
            .clk (clk),
            .a   (qe_reg[i]),
            .b   (qe_reg[3]),
            .p   (qq[i])
        );
        apd_mul #(.A_W(48), .B_W(32), .SHIFT(24)) u_gyro (
            .clk (clk),
            .a   (g1_reg[i]),
            .b   (w61[(i + 2) % 3]),
            .p   (gyro[i])
        );
        apd_mul #(.A_W(48), .B_W(33), .SHIFT(16)) u_kp (
            .clk (clk),
            .a   (qq[i]),
            .b   ($signed({1'b0, gain_prop_reg})),
            .p   (kpm[i])
        );
    end

    logic [143:0]       gyro65_bits;
    logic [143:0]       kdw65_bits;
    logic signed [47:0] gyro65 [3];
    logic signed [47:0] kdw65 [3];

    apd_delay #(.WIDTH(144), .DEPTH(2)) u_dly_gyro (
        .clk  (clk),
        .din  ({gyro[2], gyro[1], gyro[0]}),
        .dout (gyro65_bits)
    );

    apd_delay #(.WIDTH(144), .DEPTH(5)) u_dly_kd (
        .clk  (clk),
        .din  ({kdw[2], kdw[1], kdw[0]}),
        .dout (kdw65_bits)
    );

    for (genvar i = 0; i < 3; i++)
    begin : g_unpack
        assign gyro65[i] = gyro65_bits[48*i +: 48];
        assign kdw65[i]  = kdw65_bits[48*i +: 48];
    end

    // Torque, numerator and the start of the division by the inertia.
    logic [31:0]        inertia [3];
    logic signed [47:0] pd [3];
    logic signed [47:0] num [3];
    logic [46:0]        num_mag [3];
    logic [62:0]        dvd [3];
    logic [31:0]        acc_rem_reg [3];
    logic [31:0]        acc_low_reg [3];
    acc_side_t          acc_side_reg [3];

    assign inertia[0] = inertia_x_reg;
    assign inertia[1] = inertia_y_reg;
    assign inertia[2] = inertia_z_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pd[i]      = clamp_wide({kpm[i][47], kpm[i]} + {kdw65[i][47], kdw65[i]});
            num[i]     = clamp_wide({gyro65[i][47], gyro65[i]} - {pd[i][47], pd[i]});
            num_mag[i] = num[i][47] ? 47'(-num[i]) : num[i][46:0];
            dvd[i]     = {num_mag[i], 16'd0};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc_rem_reg[i]      <= {1'b0, dvd[i][62:32]};
            acc_low_reg[i]      <= dvd[i][31:0];
            // A quotient of 2^32 or more always saturates, including a zero inertia.
            acc_side_reg[i].ovf <= {1'b0, dvd[i][62:32]} >= inertia[i];
            acc_side_reg[i].neg <= num[i][47];
            acc_side_reg[i].nil <= (num[i] == '0);
        end
    end

    logic [31:0] acc_quo [3];

    for (genvar i = 0; i < 3; i++)
    begin : g_accel
        apd_div #(.Q_W(32), .D_W(32)) u_div (
            .clk      (clk),
            .rem_init (acc_rem_reg[i]),
            .low_bits (acc_low_reg[i]),
            .divisor  (inertia[i]),
            .quotient (acc_quo[i])
        );
    end

    logic [$bits(acc_side_t)*3-1:0] side98_bits;
    acc_side_t                      side98 [3];
    logic [139:0]                   r98_bits;
    logic signed [34:0]             r98 [4];
    logic                           zero98;

    apd_delay #(.WIDTH($bits(acc_side_t) * 3), .DEPTH(32)) u_dly_side (
        .clk  (clk),
        .din  ({acc_side_reg[2], acc_side_reg[1], acc_side_reg[0]}),
        .dout (side98_bits)
    );

    apd_delay #(.WIDTH(140), .DEPTH(37)) u_dly_rate (
        .clk  (clk),
        .din  ({r_reg[3], r_reg[2], r_reg[1], r_reg[0]}),
        .dout (r98_bits)
    );

    apd_delay #(.WIDTH(1), .DEPTH(97)) u_dly_zero (
        .clk  (clk),
        .din  (zero_reg),
        .dout (zero98)
    );

    for (genvar i = 0; i < 3; i++)
    begin : g_side
        assign side98[i] = acc_side_t'(side98_bits[$bits(acc_side_t)*i +: $bits(acc_side_t)]);
    end

    for (genvar i = 0; i < 4; i++)
    begin : g_rate
        assign r98[i] = r98_bits[35*i +: 35];
    end

    // Output stage.
    logic [31:0]        rate_out [4];
    logic [31:0]        acc_out [3];
    logic signed [34:0] half;
    logic signed [35:0] acc_val;
    result_t            result_next;
    result_t            result_reg;

    always_comb
    begin
        half    = '0;
        acc_val = '0;
        for (int i = 0; i < 4; i++)
        begin
            // Halving truncates towards zero.
            half        = (r98[i] + $signed({34'd0, r98[i][34]})) >>> 1;
            rate_out[i] = sat_out(36'(half));
        end
        for (int i = 0; i < 3; i++)
        begin
            if (side98[i].nil)
            begin
                acc_val = '0;
            end
            else if (side98[i].ovf)
            begin
                acc_val = side98[i].neg ? LIM_NEG : LIM;
            end
            else
            begin
                acc_val = side98[i].neg ? -$signed({4'd0, acc_quo[i]})
                                        : $signed({4'd0, acc_quo[i]});
            end
            acc_out[i] = sat_out(acc_val);
        end

        result_next.rate_quat_a = rate_out[0];
        result_next.rate_quat_b = rate_out[1];
        result_next.rate_quat_c = rate_out[2];
        result_next.rate_quat_d = rate_out[3];
        result_next.accel_x     = acc_out[0];
        result_next.accel_y     = acc_out[1];
        result_next.accel_z     = acc_out[2];
        result_next.zero_norm   = 1'b0;
        if (zero98)
        begin
            result_next           = '0;
            result_next.zero_norm = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result = result_reg;

    // A result only ever leaves for an item taken a full latency earlier.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
    else $error("result strobe without a matching item");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.zero_norm) |-> (result.rate_quat_a == 0 && result.rate_quat_b == 0 &&
            result.rate_quat_c == 0 && result.rate_quat_d == 0 && result.accel_x == 0 &&
            result.accel_y == 0 && result.accel_z == 0))
    else $error("zero-norm item with non-zero rates");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($signed(result.accel_x) <= LIM && $signed(result.accel_x) >= LIM_NEG &&
            $signed(result.rate_quat_a) <= LIM && $signed(result.rate_quat_a) >= LIM_NEG))
    else $error("result outside the output range");

endmodule
`default_nettype wire

// ===== rtl/apd_delay.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// apd_delay
// Fixed-length register delay line that keeps side data level with the
// arithmetic stages.
// ----------------------------------------------------------------------------
module apd_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] pipe_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        pipe_reg[0] <= din;
        for (int k = 1; k < DEPTH; k++)
        begin
            pipe_reg[k] <= pipe_reg[k-1];
        end
    end

    assign dout = pipe_reg[DEPTH-1];

endmodule
`default_nettype wire

// ===== rtl/apd_mul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// apd_mul
// Two-stage signed multiply, scaled down by a fixed shift with truncation
// towards zero and a magnitude limit of 2^47 - 1.
// ----------------------------------------------------------------------------
module apd_mul
    import apd_pkg::*;
#(
    parameter int A_W   = 33,
    parameter int B_W   = 32,
    parameter int SHIFT = 16
) (
    input  logic                     clk,
    input  logic signed [A_W-1:0]    a,
    input  logic signed [B_W-1:0]    b,
    output logic signed [WIDE_W-1:0] p
);

    localparam int LO_W = A_W / 2;
    localparam int HI_W = A_W - LO_W;
    localparam int P_W  = A_W + B_W;

    logic [A_W-1:0]        a_mag;
    logic [B_W-1:0]        b_mag;
    logic [LO_W+B_W-1:0]   lo_reg;
    logic [HI_W+B_W-1:0]   hi_reg;
    logic                  neg_reg;
    logic [P_W-1:0]        full;
    logic [P_W-1:0]        shifted;
    logic                  sat;
    logic [WIDE_W-1:0]     mag_sat;

    assign a_mag = a[A_W-1] ? $unsigned(-a) : $unsigned(a);
    assign b_mag = b[B_W-1] ? $unsigned(-b) : $unsigned(b);

    // The first operand is split in two so that each partial product stays narrow.
    always_ff @(posedge clk)
    begin
        lo_reg  <= a_mag[LO_W-1:0] * b_mag;
        hi_reg  <= a_mag[A_W-1:LO_W] * b_mag;
        neg_reg <= a[A_W-1] ^ b[B_W-1];
    end

    assign full    = {hi_reg, {LO_W{1'b0}}} + P_W'(lo_reg);
    assign shifted = full >> SHIFT;
    assign sat     = |shifted[P_W-1:WIDE_W-1];
    assign mag_sat = sat ? WIDE_MAX : {1'b0, shifted[WIDE_W-2:0]};

    always_ff @(posedge clk)
    begin
        p <= neg_reg ? -$signed(mag_sat) : $signed(mag_sat);
    end

endmodule
`default_nettype wire

// ===== rtl/apd_sqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// apd_sqrt
// Pipelined integer square root of a 64-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module apd_sqrt (
    input  logic        clk,
    input  logic [63:0] radicand,
    output logic [31:0] root
);

    localparam int STAGES = 32;

    logic [63:0] val_reg  [STAGES-1];
    logic [34:0] rem_reg  [STAGES-1];
    logic [31:0] root_reg [STAGES];

    for (genvar j = 0; j < STAGES; j++)
    begin : g_stage
        logic [63:0] val_in;
        logic [34:0] rem_in;
        logic [31:0] root_in;
        logic [36:0] part;
        logic [36:0] trial;
        logic        fits;

        if (j == 0)
        begin : g_first
            assign val_in  = radicand;
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else
        begin : g_next
            assign val_in  = val_reg[j-1];
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
        end

        // Bring down the next two radicand bits and try the digit one.
        assign part  = {rem_in, val_in[63:62]};
        assign trial = {3'b000, root_in, 2'b01};
        assign fits  = part >= trial;

        always_ff @(posedge clk)
        begin
            root_reg[j] <= {root_in[30:0], fits};
        end

        if (j < STAGES - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                val_reg[j] <= {val_in[61:0], 2'b00};
                rem_reg[j] <= fits ? 35'(part - trial) : part[34:0];
            end
        end
    end

    assign root = root_reg[STAGES-1];

endmodule
`default_nettype wire

// ===== rtl/apd_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// apd_div
// Pipelined restoring divider, one quotient bit per stage. The starting
// remainder must be below the divisor.
// ----------------------------------------------------------------------------
module apd_div #(
    parameter int Q_W = 32,
    parameter int D_W = 32
) (
    input  logic           clk,
    input  logic [D_W-1:0] rem_init,
    input  logic [Q_W-1:0] low_bits,
    input  logic [D_W-1:0] divisor,
    output logic [Q_W-1:0] quotient
);

    localparam int STAGES = Q_W;

    logic [D_W-1:0] rem_reg [STAGES-1];
    logic [Q_W-1:0] low_reg [STAGES-1];
    logic [D_W-1:0] dsr_reg [STAGES-1];
    logic [Q_W-1:0] quo_reg [STAGES];

    for (genvar j = 0; j < STAGES; j++)
    begin : g_stage
        logic [D_W-1:0] rem_in;
        logic [Q_W-1:0] low_in;
        logic [D_W-1:0] dsr_in;
        logic [Q_W-1:0] quo_in;
        logic [D_W:0]   part;
        logic           fits;

        if (j == 0)
        begin : g_first
            assign rem_in = rem_init;
            assign low_in = low_bits;
            assign dsr_in = divisor;
            assign quo_in = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[j-1];
            assign low_in = low_reg[j-1];
            assign dsr_in = dsr_reg[j-1];
            assign quo_in = quo_reg[j-1];
        end

        assign part = {rem_in, low_in[Q_W-1]};
        assign fits = part >= {1'b0, dsr_in};

        always_ff @(posedge clk)
        begin
            quo_reg[j] <= {quo_in[Q_W-2:0], fits};
        end

        if (j < STAGES - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[j] <= fits ? D_W'(part - {1'b0, dsr_in}) : part[D_W-1:0];
                low_reg[j] <= {low_in[Q_W-2:0], 1'b0};
                dsr_reg[j] <= dsr_in;
            end
        end
    end

    assign quotient = quo_reg[STAGES-1];

endmodule
`default_nettype wire
